// File: design/b64lw_pkg.sv
`default_nettype none
package b64lw_pkg;

  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_PAD       = 8'h3D;
  localparam logic [7:0] LINE_LIMIT_RST = 8'd72;
  localparam logic [7:0] LINE_LIMIT_MIN = 8'd3;
  localparam int         B64LW_QDEPTH   = 4;

  // Configuration register indexes
  localparam logic REG_LINE_LIMIT = 1'b0;

  // Group position codes
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // One classified item: up to three symbols, then an optional closing CR LF
  typedef struct packed {
    logic       finish;
    logic [1:0] nsym;
    logic [7:0] sym0;
    logic [7:0] sym1;
    logic [7:0] sym2;
  } b64lw_entry_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h47 + w;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage
`default_nettype wire

// File: design/base64_encoder_line_wrap_core.sv
`default_nettype none
// Streaming base64 encoder (A-Z a-z 0-9 + /) with MIME-style CR LF line
// breaks. Each input transfer is either a data byte (command 0) or a finish
// (command 1), which pads the partial group with '=' and always closes with
// CR LF. The front takes one transfer per cycle while its entry queue
// (QDEPTH entries, default 4) has room; the back emits one character per
// cycle while out_stall is low. An item has 1 or 2 characters for a data
// byte, 2 to 5 for a finish, plus 2 (CR LF) for each line break inserted,
// the output port setting the pace. line_limit (APB offset 0, reset 72)
// sets symbols per line; values below 3 act as 3. Write it only while the
// block is idle.
module base64_encoder_line_wrap_core import b64lw_pkg::*; #(
  parameter int QDEPTH = B64LW_QDEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             out_last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]   limit_r;
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  b64lw_entry_t q_wdata;
  b64lw_entry_t q_rdata;
  logic         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_LINE_LIMIT) && (paddr[1:0] == 2'd0);
  assign prdata  = reg_sel ? {24'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LINE_LIMIT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_r <= pwdata[7:0];
    end
  end

  b64lw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wdata)
  );

  b64lw_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  b64lw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_limit      (limit_r),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

// File: design/b64lw_front.sv
`default_nettype none
module b64lw_front import b64lw_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_command,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         q_full,
  output logic              q_push,
  output b64lw_entry_t      q_entry
);

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    pos_nxt        = pos_r;
    left_nxt       = left_r;
    q_entry.finish = in_command;
    q_entry.nsym   = 2'd0;
    q_entry.sym0   = CHAR_PAD;
    q_entry.sym1   = CHAR_PAD;
    q_entry.sym2   = CHAR_PAD;
    if (!in_command) begin
      case (pos_r)
        POS_SECOND: begin
          q_entry.nsym = 2'd1;
          q_entry.sym0 = b64_char({left_r[1:0], in_data_byte[7:4]});
          left_nxt     = in_data_byte[3:0];
          pos_nxt      = POS_THIRD;
        end
        POS_THIRD: begin
          q_entry.nsym = 2'd2;
          q_entry.sym0 = b64_char({left_r, in_data_byte[7:6]});
          q_entry.sym1 = b64_char(in_data_byte[5:0]);
          left_nxt     = 4'd0;
          pos_nxt      = POS_FIRST;
        end
        default: begin
          q_entry.nsym = 2'd1;
          q_entry.sym0 = b64_char(in_data_byte[7:2]);
          left_nxt     = {2'b00, in_data_byte[1:0]};
          pos_nxt      = POS_SECOND;
        end
      endcase
    end else begin
      case (pos_r)
        POS_SECOND: begin
          q_entry.nsym = 2'd3;
          q_entry.sym0 = b64_char({left_r[1:0], 4'd0});
        end
        POS_THIRD: begin
          q_entry.nsym = 2'd2;
          q_entry.sym0 = b64_char({left_r, 2'd0});
        end
        default: begin
          q_entry.nsym = 2'd0;
        end
      endcase
      left_nxt = 4'd0;
      pos_nxt  = POS_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_FIRST;
      left_r <= 4'd0;
    end else if (q_push) begin
      pos_r  <= pos_nxt;
      left_r <= left_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/b64lw_fifo.sv
`default_nettype none
module b64lw_fifo import b64lw_pkg::*; #(
  parameter int DEPTH = B64LW_QDEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire b64lw_entry_t push_data,
  output logic              full,
  input  wire logic         pop,
  output b64lw_entry_t      pop_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64lw_entry_t     mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// File: design/b64lw_back.sv
`default_nettype none
module b64lw_back import b64lw_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [7:0]   line_limit,
  input  wire b64lw_entry_t q_data,
  input  wire logic         q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_char,
  output logic              out_last_of_run
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SYM    = 2'd1;
  localparam logic [1:0] ST_BRK_LF = 2'd2;
  localparam logic [1:0] ST_FIN_LF = 2'd3;

  logic [1:0]   state_r, state_nxt;
  b64lw_entry_t ent_r, ent_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         ov_r, ov_nxt;
  logic [7:0]   char_r, char_nxt;
  logic         last_r, last_nxt;
  logic         slot_free;
  logic         done;
  logic [7:0]   lim;
  logic [7:0]   cur_sym;

  assign slot_free       = !ov_r || !out_stall;
  assign lim             = (line_limit < LINE_LIMIT_MIN) ? LINE_LIMIT_MIN : line_limit;
  assign out_valid       = ov_r;
  assign out_char        = char_r;
  assign out_last_of_run = last_r;

  always_comb begin
    case (idx_r)
      2'd0:    cur_sym = ent_r.sym0;
      2'd1:    cur_sym = ent_r.sym1;
      default: cur_sym = ent_r.sym2;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && out_stall;
    char_nxt  = char_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    done      = 1'b0;
    if (slot_free) begin
      case (state_r)
        ST_SYM: begin
          if (idx_r < ent_r.nsym) begin
            ov_nxt = 1'b1;
            if (cnt_r >= lim) begin
              // break the line before this symbol
              char_nxt  = CHAR_CR;
              last_nxt  = 1'b0;
              cnt_nxt   = 8'd0;
              state_nxt = ST_BRK_LF;
            end else begin
              char_nxt = cur_sym;
              cnt_nxt  = cnt_r + 8'd1;
              idx_nxt  = idx_r + 2'd1;
              last_nxt = (idx_r == ent_r.nsym - 2'd1) && !ent_r.finish;
              done     = (idx_r == ent_r.nsym - 2'd1) && !ent_r.finish;
            end
          end else begin
            ov_nxt    = 1'b1;
            char_nxt  = CHAR_CR;
            last_nxt  = 1'b0;
            state_nxt = ST_FIN_LF;
          end
        end
        ST_BRK_LF: begin
          ov_nxt    = 1'b1;
          char_nxt  = CHAR_LF;
          last_nxt  = 1'b0;
          state_nxt = ST_SYM;
        end
        ST_FIN_LF: begin
          ov_nxt   = 1'b1;
          char_nxt = CHAR_LF;
          last_nxt = 1'b1;
          cnt_nxt  = 8'd0;
          done     = 1'b1;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
    // take the next entry as soon as the current one is finished
    if ((state_r == ST_IDLE || done) && !q_empty) begin
      q_pop     = 1'b1;
      ent_nxt   = q_data;
      idx_nxt   = 2'd0;
      state_nxt = ST_SYM;
    end else if (done) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
      cnt_r   <= 8'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

`ifndef SYNTHESIS
  a_last_not_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && last_r) |-> (char_r != CHAR_CR)) else $error("run ends on CR");
  a_brk_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BRK_LF || state_r == ST_FIN_LF) |-> (ov_r && char_r == CHAR_CR))
    else $error("LF pending without CR shown");
  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE || done)) else $error("entry replaced while busy");
`endif

endmodule
`default_nettype wire
